FILE: design/cdstep_pkg.sv
// ----------------------------------------------------------------------------
// cdstep_pkg
// shared types, command codes and the month length table for the date stepper
// ----------------------------------------------------------------------------
package cdstep_pkg;

  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DATA_W  = YEAR_W + MONTH_W + DAY_W;

  localparam logic [YEAR_W-1:0]  YEAR_SPAN = 7'd100;
  localparam logic [YEAR_W-1:0]  YEAR_LAST = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_DEC_LEN = 5'd31;

  typedef enum logic [1:0] {
    CMD_NEXT_DAY   = 2'd0,
    CMD_PREV_DAY   = 2'd1,
    CMD_NEXT_MONTH = 2'd2,
    CMD_PREV_MONTH = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // month length, february stretched in a leap year; other codes read 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      unique case (month)
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd4,
        4'd6,
        4'd9,
        4'd11:   len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

FILE: design/calendar_date_stepper_core.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// steps a date in 2000..2099 by one day or one month, forward or back
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: tdata carries year, month and day, tuser the command.
//   output stream m_*: tdata carries the stepped date, tuser the bad-date flag.
//   every accepted input gives exactly one output transfer, in order.
// order: a date passes the input register, then the result register behind the
//   date logic; m_tvalid rises when the result register is loaded, and the
//   output transfer comes once m_tready is high.
// throughput: one date per cycle; the input and result registers advance
//   together whenever the result register is empty or being taken.
// stall: while m_tready is low the result holds; one more date is taken into
//   the input register only if it is empty, then s_tready stays low until the stall ends.
// reset: rst (synchronous, active high) empties both registers; no clearing
//   pass, s_tready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module calendar_date_stepper_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cdstep_pkg::DATA_W-1:0] s_tdata,   // year_in[6:0], month_in[10:7], day_in[15:11]
  input  logic [1:0]                    s_tuser,   // command[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cdstep_pkg::DATA_W-1:0] m_tdata,   // year_out[6:0], month_out[10:7], day_out[15:11]
  output logic                          m_tuser    // bad_date[0]
);
  import cdstep_pkg::*;

  logic  in_valid;
  date_t in_date;
  cmd_t  in_cmd;
  logic  advance;
  date_t calc_date;
  logic  calc_bad;

  // pipeline moves when the result register is free or taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_date <= date_t'(s_tdata);
      in_cmd  <= cmd_t'(s_tuser);
    end
  end

  cdstep_calc u_calc (
    .cmd      (in_cmd),
    .date_in  (in_date),
    .date_out (calc_date),
    .bad_date (calc_bad)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= calc_date;
      m_tuser <= calc_bad;
    end
  end

endmodule

FILE: design/cdstep_calc.sv
// ----------------------------------------------------------------------------
// cdstep_calc
// combinational date step: range check, day and month stepping, year wrap
// ----------------------------------------------------------------------------
module cdstep_calc (
  input  cdstep_pkg::cmd_t  cmd,
  input  cdstep_pkg::date_t date_in,
  output cdstep_pkg::date_t date_out,
  output logic              bad_date
);
  import cdstep_pkg::*;

  logic [YEAR_W-1:0]  yr;
  logic [YEAR_W-1:0]  yr_inc;
  logic [YEAR_W-1:0]  yr_dec;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic [MONTH_W-1:0] mo_inc;
  logic [MONTH_W-1:0] mo_dec;

  // reduce year to 0..99, leap test (2000 is a leap year, 2100 out of range)
  assign yr     = (date_in.year >= YEAR_SPAN) ? date_in.year - YEAR_SPAN : date_in.year;
  assign leap   = (yr[1:0] == 2'b00);
  assign yr_inc = (yr == YEAR_LAST) ? '0 : yr + 7'd1;
  assign yr_dec = (yr == '0) ? YEAR_LAST : yr - 7'd1;
  assign len    = month_len(date_in.month, leap);
  assign mo_inc = date_in.month + 4'd1;
  assign mo_dec = date_in.month - 4'd1;

  // range check
  assign bad_date = (date_in.month == '0) || (date_in.month > MONTH_DEC) ||
                    (date_in.day == '0) || (date_in.day > len);

  // step per command; on a bad date month and day pass through, year only reduced
  always_comb begin
    date_out.year  = yr;
    date_out.month = date_in.month;
    date_out.day   = date_in.day;
    if (!bad_date) begin
      unique case (cmd)
        CMD_NEXT_DAY: begin
          if (date_in.day == len) begin
            date_out.day = DAY_FIRST;
            if (date_in.month == MONTH_DEC) begin
              date_out.month = MONTH_JAN;
              date_out.year  = yr_inc;
            end else begin
              date_out.month = mo_inc;
            end
          end else begin
            date_out.day = date_in.day + 5'd1;
          end
        end
        CMD_PREV_DAY: begin
          if (date_in.day == DAY_FIRST) begin
            if (date_in.month == MONTH_JAN) begin
              date_out.month = MONTH_DEC;
              date_out.year  = yr_dec;
              date_out.day   = DAY_DEC_LEN;
            end else begin
              date_out.month = mo_dec;
              date_out.day   = month_len(mo_dec, leap);
            end
          end else begin
            date_out.day = date_in.day - 5'd1;
          end
        end
        CMD_NEXT_MONTH: begin
          if (date_in.month == MONTH_DEC) begin
            date_out.month = MONTH_JAN;
            date_out.year  = yr_inc;
          end else begin
            date_out.month = mo_inc;
          end
        end
        CMD_PREV_MONTH: begin
          if (date_in.month == MONTH_JAN) begin
            date_out.month = MONTH_DEC;
            date_out.year  = yr_dec;
          end else begin
            date_out.month = mo_dec;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/cdstep_checker.sv
// ----------------------------------------------------------------------------
// cdstep_checker
// port-level checks on the date stepper, bound to the top level
// ----------------------------------------------------------------------------
module cdstep_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // offered input waits unchanged until it is taken
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("waiting input changed");

  // year always reduced to 0..99
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:0] <= 7'd99)
    else $error("year out of range");

  // a good result has a real month and a nonzero day
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[10:7] != 4'd0 && m_tdata[10:7] <= 4'd12 &&
                             m_tdata[15:11] != 5'd0)
    else $error("good result with bad month or day");

endmodule

bind calendar_date_stepper_core cdstep_checker u_cdstep_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
